@@ sv/ebalc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent block allocator package
// Shared widths, codes, command and configuration types.
// ----------------------------------------------------------------------------
package ebalc_pkg;

  localparam int BN_W = 36;   // block number width
  localparam int FC_W = 37;   // free count width
  localparam int UB_W = 48;   // initial used bytes width
  localparam int N_W  = 19;   // run length width (up to 262144)
  localparam int CFG_W = 48;  // config write data width

  localparam int DEF_MAX_EXTENTS = 64;
  localparam int DEF_BLOCK_SHIFT = 12;

  typedef enum logic [1:0] {
    ACT_INIT  = 2'd0,
    ACT_ALLOC = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_NOP   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    SC_ONE   = 2'd0,
    SC_512   = 2'd1,
    SC_256K  = 2'd2,
    SC_NONE  = 2'd3
  } size_class_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_NOT_FOUND  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_REGION_START = 2'd0,
    REG_REGION_END   = 2'd1,
    REG_USED_BYTES   = 2'd2,
    REG_FREE_BLOCKS  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    K_INIT,
    K_ALLOC,
    K_FREE,
    K_NOP,
    K_NO_SPACE,
    K_NOT_FOUND
  } kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_AL_RD0,
    S_AL_LD0,
    S_AL_FETCH,
    S_AL_EVAL,
    S_FR_RD,
    S_FR_EVAL,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_WR_A,
    S_WR_B,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [BN_W-1:0]   lo;
    logic [BN_W:0]     hi;
    logic [N_W-1:0]    n;
  } cmd_t;

  typedef struct packed {
    logic [BN_W-1:0] low;
    logic [BN_W-1:0] high;
  } ext_t;

  typedef struct packed {
    logic [BN_W-1:0] region_start;
    logic [BN_W-1:0] region_end;
    logic [UB_W-1:0] used_bytes;
    logic [FC_W-1:0] free_init;
  } cfg_t;

  function automatic logic [N_W-1:0] run_blocks(input logic [1:0] sc);
    logic [N_W-1:0] r;
    case (size_class_t'(sc))
      SC_ONE:  r = N_W'(1);
      SC_512:  r = N_W'(512);
      SC_256K: r = N_W'(262144);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/ebalc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent allocator front end
// Accept items, classify them and hold them in a two-entry command queue.
// ----------------------------------------------------------------------------
module ebalc_front
  import ebalc_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      action,
  input  logic [BN_W-1:0] block_number,
  input  logic [1:0]      size_class,
  output logic            cmd_valid,
  output cmd_t            cmd,
  input  logic            cmd_pop
);

  cmd_t           cls;
  logic [N_W-1:0] n;
  cmd_t           q [2];
  logic           wp;
  logic           rp;
  logic [1:0]     cnt;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    n      = run_blocks(size_class);
    cls.lo = block_number;
    cls.n  = n;
    cls.hi = {1'b0, block_number} + {{(BN_W+1-N_W){1'b0}}, n} - (BN_W+1)'(1);
    case (action_t'(action))
      ACT_INIT:  cls.kind = K_INIT;
      ACT_ALLOC: cls.kind = (n == '0) ? K_NO_SPACE : K_ALLOC;
      ACT_FREE:  cls.kind = (n == '0) ? K_NOT_FOUND : K_FREE;
      default:   cls.kind = K_NOP;
    endcase
  end

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) wp <= ~wp;
      if (do_pop)  rp <= ~rp;
      case ({do_push, do_pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

@@ sv/ebalc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent allocator back end
// Walk the extent table, shift entries on insert or delete, post results.
// ----------------------------------------------------------------------------
module ebalc_back
  import ebalc_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int BLOCK_SHIFT = DEF_BLOCK_SHIFT
)
(
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            cmd_valid,
  input  cmd_t            cmd,
  output logic            cmd_pop,
  input  logic            pop,
  output logic            empty,
  output logic [1:0]      status,
  output logic [BN_W-1:0] start_block,
  output logic [FC_W-1:0] free_blocks
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] C_ONE = CW'(1);
  localparam logic [CW-1:0] C_MAX = CW'(MAX_EXTENTS);
  localparam int US_W = UB_W + 1;

  ext_t mem [MAX_EXTENTS];
  ext_t rd;

  state_t state, state_next;

  cmd_t            c;
  logic [CW-1:0]   idx, cnt, j, p;
  ext_t            cur;
  logic            wa_v, wb_v;
  logic [AW-1:0]   wa_addr, wb_addr;
  ext_t            wa_data, wb_data;
  status_t         pend_status;
  logic [BN_W-1:0] pend_start;
  logic [FC_W-1:0] fcnt;
  logic            res_v;
  status_t         res_status;
  logic [BN_W-1:0] res_start;
  logic [FC_W-1:0] res_free;

  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  ext_t            mem_wd;

  logic [CW-1:0]   idx_n, jn, jm;
  logic            has_next, full_tab, res_load;
  logic [BN_W-1:0] n36, next_low, gap, al_lo;
  logic [BN_W:0]   al_hi;
  logic            al_fit, al_abut, al_ok, al_merge, al_prep, al_ins, al_stuck;
  logic            fr_past, fr_lo_eq, fr_lo_gt, fr_hi_eq, fr_hi_lt;
  logic            fr_exact, fr_left, fr_right, fr_inside, fr_ok, fr_stuck;
  logic [BN_W-1:0] hi_p1, lo_m1;
  logic [FC_W-1:0] fc_sub_v, fc_add_v, init_fc;
  logic [FC_W:0]   fc_sum;
  logic [US_W-1:0] used_sum, used;
  logic [BN_W-1:0] init_high;

  // datapath decisions
  always_comb begin
    idx_n    = idx + C_ONE;
    jn       = j + C_ONE;
    jm       = j - C_ONE;
    has_next = idx_n < cnt;
    full_tab = (cnt == C_MAX);
    n36      = {{(BN_W-N_W){1'b0}}, c.n};

    next_low = has_next ? rd.low : cfg.region_end;
    gap      = cur.high + BN_W'(1);
    al_lo    = (cur.high + n36) & ~(n36 - BN_W'(1));
    al_hi    = {1'b0, al_lo} + {1'b0, n36} - (BN_W+1)'(1);
    al_fit   = al_hi < {1'b0, next_low};
    al_abut  = ((al_hi + (BN_W+1)'(1)) == {1'b0, next_low}) && has_next;
    al_ok    = al_fit && (al_lo >= gap);
    al_merge = (al_lo == gap) && al_abut;
    al_prep  = (al_lo > gap) && al_abut;
    al_ins   = (al_lo > gap) && !al_abut;
    al_stuck = al_ins && full_tab;

    fr_past   = c.lo > rd.high;
    fr_lo_eq  = c.lo == rd.low;
    fr_lo_gt  = c.lo > rd.low;
    fr_hi_eq  = c.hi == {1'b0, rd.high};
    fr_hi_lt  = c.hi < {1'b0, rd.high};
    fr_exact  = fr_lo_eq && fr_hi_eq;
    fr_left   = fr_lo_eq && fr_hi_lt;
    fr_right  = fr_lo_gt && fr_hi_eq;
    fr_inside = fr_lo_gt && fr_hi_lt;
    fr_ok     = !fr_past && (fr_exact || fr_left || fr_right || fr_inside);
    fr_stuck  = fr_inside && full_tab;
    hi_p1     = c.hi[BN_W-1:0] + BN_W'(1);
    lo_m1     = c.lo - BN_W'(1);

    fc_sub_v = (fcnt > {{(FC_W-N_W){1'b0}}, c.n}) ? fcnt - {{(FC_W-N_W){1'b0}}, c.n} : '0;
    fc_sum   = {1'b0, fcnt} + {{(FC_W+1-N_W){1'b0}}, c.n};
    fc_add_v = fc_sum[FC_W] ? {FC_W{1'b1}} : fc_sum[FC_W-1:0];

    used_sum  = {1'b0, cfg.used_bytes} + US_W'((64'd1 << BLOCK_SHIFT) - 64'd1);
    used      = used_sum >> BLOCK_SHIFT;
    init_high = cfg.region_start + used[BN_W-1:0] - BN_W'(1);
    init_fc   = ({{(US_W-FC_W){1'b0}}, cfg.free_init} > used)
              ? cfg.free_init - used[FC_W-1:0] : '0;

    res_load = (state == S_DONE) && (!res_v || pop);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            K_INIT:  state_next = S_INIT;
            K_ALLOC: state_next = (cnt == '0) ? S_DONE : S_AL_RD0;
            K_FREE:  state_next = (cnt == '0) ? S_DONE : S_FR_RD;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_INIT:     state_next = S_DONE;
      S_AL_RD0:   state_next = S_AL_LD0;
      S_AL_LD0:   state_next = S_AL_FETCH;
      S_AL_FETCH: state_next = S_AL_EVAL;
      S_AL_EVAL: begin
        if (!al_ok)        state_next = has_next ? S_AL_FETCH : S_DONE;
        else if (al_stuck) state_next = S_DONE;
        else if (al_merge) state_next = S_DEL_RD;
        else if (al_ins)   state_next = S_INS_RD;
        else               state_next = S_WR_A;
      end
      S_FR_RD: state_next = S_FR_EVAL;
      S_FR_EVAL: begin
        if (!fr_ok)         state_next = has_next ? S_FR_RD : S_DONE;
        else if (fr_stuck)  state_next = S_DONE;
        else if (fr_exact)  state_next = S_DEL_RD;
        else if (fr_inside) state_next = S_INS_RD;
        else                state_next = S_WR_A;
      end
      S_DEL_RD: state_next = (jn < cnt) ? S_DEL_WR : S_WR_A;
      S_DEL_WR: state_next = S_DEL_RD;
      S_INS_RD: state_next = (j > p) ? S_INS_WR : S_WR_A;
      S_INS_WR: state_next = S_INS_RD;
      S_WR_A:   state_next = S_WR_B;
      S_WR_B:   state_next = S_DONE;
      S_DONE:   state_next = (!res_v || pop) ? S_IDLE : S_DONE;
      default:  state_next = S_IDLE;
    endcase
  end

  // memory port and queue pop
  always_comb begin
    mem_we  = 1'b0;
    mem_wa  = '0;
    mem_wd  = wa_data;
    mem_ra  = '0;
    cmd_pop = 1'b0;
    case (state)
      S_IDLE:     cmd_pop = cmd_valid;
      S_INIT: begin
        mem_we = 1'b1;
        mem_wd = '{low: cfg.region_start, high: init_high};
      end
      S_AL_FETCH: mem_ra = idx_n[AW-1:0];
      S_FR_RD:    mem_ra = idx[AW-1:0];
      S_DEL_RD:   mem_ra = jn[AW-1:0];
      S_INS_RD:   mem_ra = jm[AW-1:0];
      S_DEL_WR, S_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = j[AW-1:0];
        mem_wd = rd;
      end
      S_WR_A: begin
        mem_we = wa_v;
        mem_wa = wa_addr;
      end
      S_WR_B: begin
        mem_we = wb_v;
        mem_wa = wb_addr;
        mem_wd = wb_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd <= mem[mem_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      fcnt  <= '0;
      res_v <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_INIT: begin
          cnt  <= C_ONE;
          fcnt <= init_fc;
        end
        S_AL_EVAL: if (al_ok && !al_stuck) fcnt <= fc_sub_v;
        S_FR_EVAL: if (fr_ok && !fr_stuck) fcnt <= fc_add_v;
        S_DEL_RD:  if (!(jn < cnt)) cnt <= cnt - C_ONE;
        S_INS_RD:  if (!(j > p)) cnt <= cnt + C_ONE;
        default: ;
      endcase
      if (res_load)   res_v <= 1'b1;
      else if (pop)   res_v <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        c          <= cmd;
        idx        <= '0;
        pend_start <= '0;
        wa_v       <= 1'b0;
        wb_v       <= 1'b0;
        case (cmd.kind)
          K_NO_SPACE:  pend_status <= ST_NO_SPACE;
          K_NOT_FOUND: pend_status <= ST_NOT_FOUND;
          K_ALLOC:     pend_status <= (cnt == '0) ? ST_NO_SPACE : ST_OK;
          K_FREE:      pend_status <= (cnt == '0) ? ST_NOT_FOUND : ST_OK;
          default:     pend_status <= ST_OK;
        endcase
      end
      S_AL_LD0: cur <= rd;
      S_AL_EVAL: begin
        if (!al_ok) begin
          if (has_next) begin
            cur <= rd;
            idx <= idx_n;
          end else begin
            pend_status <= ST_NO_SPACE;
          end
        end else if (al_stuck) begin
          pend_status <= ST_TABLE_FULL;
        end else begin
          pend_start <= al_lo;
          wa_v       <= 1'b1;
          if (al_merge) begin
            wa_addr <= idx[AW-1:0];
            wa_data <= '{low: cur.low, high: rd.high};
            j       <= idx_n;
          end else if (al_lo == gap) begin
            wa_addr <= idx[AW-1:0];
            wa_data <= '{low: cur.low, high: al_hi[BN_W-1:0]};
          end else if (al_prep) begin
            wa_addr <= idx_n[AW-1:0];
            wa_data <= '{low: al_lo, high: rd.high};
          end else begin
            wa_addr <= idx_n[AW-1:0];
            wa_data <= '{low: al_lo, high: al_hi[BN_W-1:0]};
            j       <= cnt;
            p       <= idx_n;
          end
        end
      end
      S_FR_EVAL: begin
        if (!fr_ok) begin
          if (has_next) idx <= idx_n;
          else          pend_status <= ST_NOT_FOUND;
        end else if (fr_stuck) begin
          pend_status <= ST_TABLE_FULL;
        end else if (fr_exact) begin
          j <= idx;
        end else if (fr_left) begin
          wa_v    <= 1'b1;
          wa_addr <= idx[AW-1:0];
          wa_data <= '{low: hi_p1, high: rd.high};
        end else if (fr_right) begin
          wa_v    <= 1'b1;
          wa_addr <= idx[AW-1:0];
          wa_data <= '{low: rd.low, high: lo_m1};
        end else begin
          // split: upper part goes into a new entry after this one
          wa_v    <= 1'b1;
          wa_addr <= idx_n[AW-1:0];
          wa_data <= '{low: hi_p1, high: rd.high};
          wb_v    <= 1'b1;
          wb_addr <= idx[AW-1:0];
          wb_data <= '{low: rd.low, high: lo_m1};
          j       <= cnt;
          p       <= idx_n;
        end
      end
      S_DEL_WR: j <= jn;
      S_INS_WR: j <= jm;
      default: ;
    endcase
    if (res_load) begin
      res_status <= pend_status;
      res_start  <= pend_start;
      res_free   <= fcnt;
    end
  end

  assign empty       = !res_v;
  assign status      = res_status;
  assign start_block = res_start;
  assign free_blocks = res_free;

endmodule

@@ sv/extent_block_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent block allocator
// Sorted table of in-use extents with a free block counter.
// ----------------------------------------------------------------------------
// Allocate and free walk the table one extent at a time. Insert or delete shifts
// table entries one at a time through the extent memory, each read and then
// written back; the memory has one write port and one registered read port.
// One item is worked at a time; up to two more wait in the command queue.
// Reset (rst, synchronous) empties the table and both queues, zeroes the free count and config registers.

module extent_block_allocator_unit
  import ebalc_pkg::*;
#(
  parameter int MAX_EXTENTS = DEF_MAX_EXTENTS,
  parameter int BLOCK_SHIFT = DEF_BLOCK_SHIFT
)
(
  input  logic             clk,
  input  logic             rst,
  // configuration writes
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // item input queue
  input  logic             push,
  output logic             full,
  input  logic [1:0]       action,
  input  logic [BN_W-1:0]  block_number,
  input  logic [1:0]       size_class,
  // result queue
  input  logic             pop,
  output logic             empty,
  output logic [1:0]       status,
  output logic [BN_W-1:0]  start_block,
  output logic [FC_W-1:0]  free_blocks
);

  cfg_t cfg;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  // Configuration registers; the user must ensure they are written only while the block is idle; not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_REGION_START: cfg.region_start <= cfg_data[BN_W-1:0];
        REG_REGION_END:   cfg.region_end   <= cfg_data[BN_W-1:0];
        REG_USED_BYTES:   cfg.used_bytes   <= cfg_data[UB_W-1:0];
        REG_FREE_BLOCKS:  cfg.free_init    <= cfg_data[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: decode action and size class, queue the command.
  ebalc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .action       (action),
    .block_number (block_number),
    .size_class   (size_class),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Back: walk and edit the extent table, hold one finished result.
  ebalc_back #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .BLOCK_SHIFT (BLOCK_SHIFT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .pop         (pop),
    .empty       (empty),
    .status      (status),
    .start_block (start_block),
    .free_blocks (free_blocks)
  );

endmodule

@@ sv/ebalc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent allocator port checker
// Watch the queue ports for lost, invented or malformed results.
// ----------------------------------------------------------------------------
module ebalc_checker
  import ebalc_pkg::*;
(
  input logic            clk,
  input logic            rst,
  input logic            push,
  input logic            full,
  input logic            pop,
  input logic            empty,
  input logic [1:0]      status,
  input logic [BN_W-1:0] start_block,
  input logic [FC_W-1:0] free_blocks
);

  logic [2:0] outst;

  always_ff @(posedge clk) begin
    if (rst) begin
      outst <= '0;
    end else begin
      outst <= outst + 3'((push && !full) ? 1 : 0) - 3'((pop && !empty) ? 1 : 0);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_err_zero_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && status != ST_OK) |-> start_block == '0)
    else $error("failed item carries a start block");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(start_block)
                          && $stable(free_blocks)))
    else $error("waiting result changed");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    !empty |-> outst != 3'd0)
    else $error("result without an accepted item");

  a_bound: assert property (@(posedge clk) disable iff (rst) outst <= 3'd4)
    else $error("too many items in flight");

endmodule

bind extent_block_allocator_unit ebalc_checker u_chk (.*);
